[sv/tms_pkg.sv]
// Shared types and constants of the tile map scroll renderer.
`default_nettype none

package tms_pkg;

    // Map and tile geometry (power-of-two sizes)
    localparam int MAP_ROWS       = 8;
    localparam int MAP_COLS       = 16;
    localparam int TILE_COUNT     = 32;
    localparam int SCREEN_COLUMNS = 128;
    localparam int TILE_PIX       = 8;

    localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
    localparam int PAT_DEPTH = TILE_COUNT * TILE_PIX;
    localparam int MAP_WIDTH = MAP_COLS * TILE_PIX;

    localparam int ROW_W  = $clog2(MAP_ROWS);
    localparam int TCOL_W = $clog2(MAP_COLS);
    localparam int SUB_W  = $clog2(TILE_PIX);
    localparam int GX_W   = $clog2(MAP_WIDTH);
    localparam int TILE_W = $clog2(TILE_COUNT);
    localparam int MAP_AW = ROW_W + TCOL_W;
    localparam int PAT_AW = TILE_W + SUB_W;

    // Port field widths
    localparam int OP_W    = 2;
    localparam int MADDR_W = 7;
    localparam int PADDR_W = 8;
    localparam int DATA_W  = 8;
    localparam int PAGE_W  = 3;
    localparam int COL_W   = 7;
    localparam int MAP_W   = 5;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MAP_WR = 2'd0;
    localparam logic [OP_W-1:0] OP_PAT_WR = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        K_MAP_WR = 2'd0,
        K_PAT_WR = 2'd1,
        K_FETCH  = 2'd2
    } t_kind;

    // One decoded command as it travels from front to back
    typedef struct packed {
        t_kind               kind;
        logic [MAP_AW-1:0]   map_addr;
        logic [PAT_AW-1:0]   pat_addr;
        logic [DATA_W-1:0]   wval;
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    below;
        logic [TCOL_W-1:0]   tcol;
        logic [SUB_W-1:0]    sub;
        logic [SUB_W-1:0]    voff;
    } t_cmd;

endpackage

`default_nettype wire

[sv/tms_front.sv]
// Command front end: scroll registers, command decode and fetch address math.
`default_nettype none

module tms_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [tms_pkg::OP_W-1:0]      i_operation,
    input  wire logic [tms_pkg::MADDR_W-1:0]   i_map_address,
    input  wire logic [tms_pkg::PADDR_W-1:0]   i_pattern_address,
    input  wire logic [tms_pkg::DATA_W-1:0]    i_write_value,
    input  wire logic [tms_pkg::PAGE_W-1:0]    i_page,
    input  wire logic [tms_pkg::COL_W-1:0]     i_column,
    input  wire logic                          i_cfg_wr,
    input  wire logic [tms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tms_pkg::DATA_W-1:0]    i_cfg_data,
    output logic                               o_push,
    output tms_pkg::t_cmd                      o_cmd
);
    import tms_pkg::*;

    logic [DATA_W-1:0] r_scroll_x;
    logic [DATA_W-1:0] r_scroll_y;

    logic [COL_W-1:0]  scr_col;
    logic [DATA_W:0]   gx_sum;
    logic [GX_W-1:0]   gx;
    logic [DATA_W:0]   row_sum;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  below;
    logic              map_ok;
    logic              pat_ok;

    // Scroll registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                REG_SCROLL_X: r_scroll_x <= i_cfg_data;
                REG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global column and map rows of a fetch (all moduli are powers of two)
    always_comb begin
        scr_col = COL_W'(i_column % SCREEN_COLUMNS);
        gx_sum  = (DATA_W+1)'(r_scroll_x) + (DATA_W+1)'(scr_col);
        gx      = GX_W'(gx_sum % MAP_WIDTH);
        row_sum = (DATA_W+1)'(r_scroll_y >> SUB_W) + (DATA_W+1)'(i_page);
        row     = ROW_W'(row_sum % MAP_ROWS);
        below   = ROW_W'(((ROW_W+1)'(row) + (ROW_W+1)'(1)) % MAP_ROWS);
        map_ok  = 32'(i_map_address) < MAP_DEPTH;
        pat_ok  = 32'(i_pattern_address) < PAT_DEPTH;
    end

    // Classify the command; drop unknown operations and out-of-range writes
    always_comb begin
        o_cmd          = '0;
        o_cmd.map_addr = MAP_AW'(i_map_address);
        o_cmd.pat_addr = PAT_AW'(i_pattern_address);
        o_cmd.wval     = i_write_value;
        o_cmd.row      = row;
        o_cmd.below    = below;
        o_cmd.tcol     = TCOL_W'(gx >> SUB_W);
        o_cmd.sub      = SUB_W'(gx % TILE_PIX);
        o_cmd.voff     = SUB_W'(r_scroll_y % TILE_PIX);
        o_push         = 1'b0;
        unique case (i_operation)
            OP_MAP_WR: begin
                o_cmd.kind = K_MAP_WR;
                o_push     = i_accept && map_ok;
            end
            OP_PAT_WR: begin
                o_cmd.kind = K_PAT_WR;
                o_push     = i_accept && pat_ok;
            end
            OP_FETCH: begin
                o_cmd.kind = K_FETCH;
                o_push     = i_accept;
            end
            default: begin
                o_cmd.kind = K_FETCH;
                o_push     = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/tms_queue.sv]
// Short command queue between the front end and the render back end.
`default_nettype none

module tms_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  tms_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output tms_pkg::t_cmd      o_head
);
    import tms_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        priority if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'((32'(r_wr_ptr) + 1) % QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'((32'(r_rd_ptr) + 1) % QUEUE_DEPTH);
            end
            r_count <= n_count;
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH) else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");

endmodule

`default_nettype wire

[sv/tms_back.sv]
// Render back end: map and pattern memories, byte merge and result register.
`default_nettype none

module tms_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  tms_pkg::t_cmd                    i_cmd,
    output logic                             o_strobe,
    output logic [tms_pkg::DATA_W-1:0]       o_display_byte
);
    import tms_pkg::*;

    logic [MAP_W-1:0]  r_map_mem [MAP_DEPTH];
    logic [DATA_W-1:0] r_pat_mem [PAT_DEPTH];

    // Stage B: tiles read, pattern access pending
    logic              r_b_valid;
    t_kind             r_b_kind;
    logic [PAT_AW-1:0] r_b_pat_addr;
    logic [DATA_W-1:0] r_b_wval;
    logic [SUB_W-1:0]  r_b_sub;
    logic [SUB_W-1:0]  r_b_voff;
    logic [MAP_W-1:0]  r_b_up_tile;
    logic [MAP_W-1:0]  r_b_lo_tile;

    // Stage C: pattern bytes read, merge pending
    logic              r_c_valid;
    logic [SUB_W-1:0]  r_c_voff;
    logic [DATA_W-1:0] r_c_up_byte;
    logic [DATA_W-1:0] r_c_lo_byte;

    logic              r_strobe;
    logic [DATA_W-1:0] r_byte;

    logic [MAP_AW-1:0]   up_map_addr;
    logic [MAP_AW-1:0]   lo_map_addr;
    logic [TILE_W-1:0]   up_tile;
    logic [TILE_W-1:0]   lo_tile;
    logic [PAT_AW-1:0]   up_pat_addr;
    logic [PAT_AW-1:0]   lo_pat_addr;
    logic [2*DATA_W-1:0] merged;

    // Map entry address: row * MAP_COLS + tile column
    assign up_map_addr = {i_cmd.row, i_cmd.tcol};
    assign lo_map_addr = {i_cmd.below, i_cmd.tcol};

    // Stage A: map memory, one write port and two read ports
    always_ff @(posedge i_clk) begin
        if (i_valid && i_cmd.kind == K_MAP_WR) begin
            r_map_mem[i_cmd.map_addr] <= MAP_W'(i_cmd.wval);
        end
        r_b_up_tile  <= r_map_mem[up_map_addr];
        r_b_lo_tile  <= r_map_mem[lo_map_addr];
        r_b_kind     <= i_cmd.kind;
        r_b_pat_addr <= i_cmd.pat_addr;
        r_b_wval     <= i_cmd.wval;
        r_b_sub      <= i_cmd.sub;
        r_b_voff     <= i_cmd.voff;
    end

    // Pattern address: wrapped tile * 8 + byte
    always_comb begin
        up_tile     = TILE_W'(r_b_up_tile % TILE_COUNT);
        lo_tile     = TILE_W'(r_b_lo_tile % TILE_COUNT);
        up_pat_addr = {up_tile, r_b_sub};
        lo_pat_addr = {lo_tile, r_b_sub};
    end

    // Stage B: pattern memory, one write port and two read ports
    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_kind == K_PAT_WR) begin
            r_pat_mem[r_b_pat_addr] <= r_b_wval;
        end
        r_c_up_byte <= r_pat_mem[up_pat_addr];
        r_c_lo_byte <= r_pat_mem[lo_pat_addr];
        r_c_voff    <= r_b_voff;
    end

    // Stage C: shift the two tile bytes together; offset zero gives the upper byte
    assign merged = {r_c_lo_byte, r_c_up_byte} >> r_c_voff;

    always_ff @(posedge i_clk) begin
        r_byte <= merged[DATA_W-1:0];
    end

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid && r_b_kind == K_FETCH;
            r_strobe  <= r_c_valid;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_display_byte = r_byte;

    a_stage_b_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> $past(i_valid)) else $error("tile stage valid without a command");
    a_strobe_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> $past(r_b_valid) && $past(r_b_kind) == K_FETCH)
        else $error("merge stage valid without a fetch");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_c_valid)) else $error("strobe without merge stage");

endmodule

`default_nettype wire

[sv/tile_map_scroll_renderer.sv]
// Top level of the tile map scroll renderer: front end, command queue, back end.
// A fetch accepted at one edge is written into the queue by that edge, then passes the map read,
// pattern read and merge registers in that order before its byte is strobed.
// Throughput: one command per cycle; the back end pops each queued command at once, so the
// queue never holds more than one, busy stays low, and the receiver cannot stall results.
// Reset clears the scroll registers, queue and stage valids; the memories need no clearing pass.
`default_nettype none

module tile_map_scroll_renderer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tms_pkg::OP_W-1:0]      i_operation,
    input  wire logic [tms_pkg::MADDR_W-1:0]   i_map_address,
    input  wire logic [tms_pkg::PADDR_W-1:0]   i_pattern_address,
    input  wire logic [tms_pkg::DATA_W-1:0]    i_write_value,
    input  wire logic [tms_pkg::PAGE_W-1:0]    i_page,
    input  wire logic [tms_pkg::COL_W-1:0]     i_column,
    output logic                               o_strobe,
    output logic [tms_pkg::DATA_W-1:0]         o_display_byte,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tms_pkg::DATA_W-1:0]    i_cfg_data
);
    import tms_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic head_valid;
    t_cmd cmd;
    t_cmd head;

    assign busy        = full;
    assign accept      = start && !full;
    assign o_cfg_ready = 1'b1;

    tms_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_operation      (i_operation),
        .i_map_address    (i_map_address),
        .i_pattern_address(i_pattern_address),
        .i_write_value    (i_write_value),
        .i_page           (i_page),
        .i_column         (i_column),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    // Drain one queued command per cycle into the back end
    tms_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (head_valid),
        .o_full (full),
        .o_valid(head_valid),
        .o_head (head)
    );

    tms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (head_valid),
        .i_cmd         (head),
        .o_strobe      (o_strobe),
        .o_display_byte(o_display_byte)
    );

endmodule

`default_nettype wire

[tb/sv/tile_map_scroll_renderer_checker.sv]
// Checker for the tile map scroll renderer: mirrors the tables, predicts and compares bytes.
`timescale 1ns / 100ps

module tile_map_scroll_renderer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [tms_pkg::OP_W-1:0]        i_operation,
    input  logic [tms_pkg::MADDR_W-1:0]     i_map_address,
    input  logic [tms_pkg::PADDR_W-1:0]     i_pattern_address,
    input  logic [tms_pkg::DATA_W-1:0]      i_write_value,
    input  logic [tms_pkg::PAGE_W-1:0]      i_page,
    input  logic [tms_pkg::COL_W-1:0]       i_column,
    input  logic                            i_strobe,
    input  logic [tms_pkg::DATA_W-1:0]      i_display_byte,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tms_pkg::DATA_W-1:0]      i_cfg_data,
    output int                              o_outstanding,
    output int                              o_fail_count
);
    import tms_pkg::*;

    // Mirror of the block's tables and scroll registers
    bit [MAP_W-1:0]  tile_at    [MAP_DEPTH];
    bit [DATA_W-1:0] pattern_at [PAT_DEPTH];
    bit [DATA_W-1:0] h_scroll;
    bit [DATA_W-1:0] v_scroll;

    // Display bytes still owed by the block, oldest first
    logic [DATA_W-1:0] owed_bytes [$];

    initial begin
        o_outstanding = 0;
        o_fail_count  = 0;
    end

    function automatic bit [DATA_W-1:0] pattern_byte_at(input int row, input int tcol,
                                                        input int sub);
        int tile;
        tile = int'(tile_at[row * MAP_COLS + tcol]) % TILE_COUNT;
        return pattern_at[tile * TILE_PIX + sub];
    endfunction

    // Scroll the column and band into the map, then merge the band with the row below
    function automatic logic [DATA_W-1:0] render_byte(input logic [PAGE_W-1:0] pg,
                                                      input logic [COL_W-1:0] col);
        int gx;
        int tcol;
        int sub;
        int top_row;
        int next_row;
        int shift;
        logic [2*DATA_W-1:0] merged;
        gx       = (int'(h_scroll) + int'(col) % SCREEN_COLUMNS) % MAP_WIDTH;
        tcol     = gx / TILE_PIX;
        sub      = gx % TILE_PIX;
        top_row  = (int'(v_scroll) / TILE_PIX + int'(pg)) % MAP_ROWS;
        next_row = (top_row + 1) % MAP_ROWS;
        shift    = int'(v_scroll) % TILE_PIX;
        merged   = {pattern_byte_at(next_row, tcol, sub), pattern_byte_at(top_row, tcol, sub)};
        merged   = merged >> shift;
        return merged[DATA_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            h_scroll = '0;
            v_scroll = '0;
            owed_bytes.delete();
        end else begin
            // Track register transfers
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                if (i_cfg_index == REG_SCROLL_X)
                    h_scroll = i_cfg_data;
                else if (i_cfg_index == REG_SCROLL_Y)
                    v_scroll = i_cfg_data;
            end

            // Compare each strobed byte with the oldest one owed
            if (i_strobe === 1'b1) begin
                if (owed_bytes.size() == 0) begin
                    $display("%0t: unexpected display byte, expected none, actual %02h",
                             $time, i_display_byte);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = owed_bytes.pop_front();
                    if (i_display_byte !== want) begin
                        $display("%0t: display byte mismatch, expected %02h, actual %02h",
                                 $time, want, i_display_byte);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end else if (i_strobe !== 1'b0) begin
                $display("%0t: strobe unknown, expected 0 or 1, actual %b", $time, i_strobe);
                o_fail_count <= o_fail_count + 1;
            end

            // Apply each accepted command to the mirror
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                case (i_operation)
                    OP_MAP_WR: tile_at[i_map_address]        = i_write_value[MAP_W-1:0];
                    OP_PAT_WR: pattern_at[i_pattern_address] = i_write_value;
                    OP_FETCH:  owed_bytes.push_back(render_byte(i_page, i_column));
                    default: ;
                endcase
            end
        end
        o_outstanding <= owed_bytes.size();
    end

endmodule

[tb/sv/tile_map_scroll_renderer_tb.sv]
// Testbench top for the tile map scroll renderer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tile_map_scroll_renderer_tb;
    import tms_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    localparam int RESET_CYCLES    = 6;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 106;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 start             = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_operation       = '0;
    logic [MADDR_W-1:0]   i_map_address     = '0;
    logic [PADDR_W-1:0]   i_pattern_address = '0;
    logic [DATA_W-1:0]    i_write_value     = '0;
    logic [PAGE_W-1:0]    i_page            = '0;
    logic [COL_W-1:0]     i_column          = '0;
    logic                 o_strobe;
    logic [DATA_W-1:0]    o_display_byte;
    logic                 i_cfg_valid       = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index       = '0;
    logic [DATA_W-1:0]    i_cfg_data        = '0;

    int outstanding;
    int fail_count;
    int stall_cycles = 0;

    // What the sender has written so far, so that a fetch never reads an empty entry
    logic [MAP_W-1:0] map_tiles       [MAP_DEPTH];
    bit               map_written     [MAP_DEPTH];
    bit               pattern_written [PAT_DEPTH];
    logic [DATA_W-1:0] h_scroll_set = '0;
    logic [DATA_W-1:0] v_scroll_set = '0;

    int item_count = 0;
    int idle_pct   = 0;

    tile_map_scroll_renderer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_map_address     (i_map_address),
        .i_pattern_address (i_pattern_address),
        .i_write_value     (i_write_value),
        .i_page            (i_page),
        .i_column          (i_column),
        .o_strobe          (o_strobe),
        .o_display_byte    (o_display_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    tile_map_scroll_renderer_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_operation       (i_operation),
        .i_map_address     (i_map_address),
        .i_pattern_address (i_pattern_address),
        .i_write_value     (i_write_value),
        .i_page            (i_page),
        .i_column          (i_column),
        .i_strobe          (o_strobe),
        .i_display_byte    (o_display_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_outstanding     (outstanding),
        .o_fail_count      (fail_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe === 1'b1 || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Drive one command, after an optional idle burst, and hold it until the transfer
    task automatic issue(input logic [OP_W-1:0] op, input logic [MADDR_W-1:0] maddr,
                         input logic [PADDR_W-1:0] paddr, input logic [DATA_W-1:0] wval,
                         input logic [PAGE_W-1:0] pg, input logic [COL_W-1:0] col);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 17);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_operation       <= op;
        i_map_address     <= maddr;
        i_pattern_address <= paddr;
        i_write_value     <= wval;
        i_page            <= pg;
        i_column          <= col;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (op == OP_MAP_WR) begin
            map_tiles[maddr]   = wval[MAP_W-1:0];
            map_written[maddr] = 1'b1;
        end else if (op == OP_PAT_WR) begin
            pattern_written[paddr] = 1'b1;
        end
        item_count++;
    endtask

    // Stop sending and wait until every owed byte has come and the pipe is empty
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both scroll registers back to back while the block is idle
    task automatic set_scroll(input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SCROLL_X;
        i_cfg_data  <= sx;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= REG_SCROLL_Y;
        i_cfg_data  <= sy;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        h_scroll_set = sx;
        v_scroll_set = sy;
    endtask

    initial begin
        int ph;
        int phase_end;
        int pick;
        int gx;
        int tcol;
        int sub;
        int rows_needed;
        int k;
        int row;
        int maddr;
        int paddr;
        bit paused;
        logic [PAGE_W-1:0] pg;
        logic [COL_W-1:0]  col;

        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every operation, dropped upper tile bits, ignored code
        issue(OP_MAP_WR, 7'd0, 8'hFF, 8'hE0, 3'd7, 7'd127);
        issue(OP_PAT_WR, 7'd127, 8'd0, 8'hA5, 3'd7, 7'd127);
        issue(OP_FETCH, 7'd127, 8'hFF, 8'hFF, 3'd0, 7'd0);
        issue(OP_MAP_WR, 7'd127, 8'h00, 8'hFF, 3'd0, 7'd0);
        issue(OP_PAT_WR, 7'd0, 8'hFF, 8'hFF, 3'd0, 7'd0);
        issue(OP_FETCH, 7'd0, 8'h00, 8'h00, 3'd7, 7'd127);
        issue(OP_IGNORED, 7'd0, 8'h00, 8'h00, 3'd0, 7'd0);
        issue(OP_IGNORED, 7'd127, 8'hFF, 8'hFF, 3'd7, 7'd127);
        issue(OP_FETCH, 7'd0, 8'h00, 8'h00, 3'd0, 7'd0);
        issue(OP_FETCH, 7'd127, 8'hFF, 8'hFF, 3'd7, 7'd127);

        // Random phases, each under its own scroll setting
        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: set_scroll(8'hFF, 8'hFF);
                1: set_scroll(8'h00, 8'h07);
                2: set_scroll(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
                3: set_scroll(8'h80, 8'h01);
                4: set_scroll(DATA_W'($urandom_range(0, 255)), 8'h00);
                default: set_scroll(DATA_W'($urandom_range(0, 255)),
                                    DATA_W'($urandom_range(0, 255)));
            endcase
            idle_pct  = (ph == 1 || ph == PHASES - 1) ? 0 : 30;
            phase_end = item_count + ITEMS_PER_PHASE;
            while (item_count < phase_end) begin
                // In phase 2 only, hold off once mid-phase until nothing is owed
                if (ph == 2 && !paused && item_count >= phase_end - ITEMS_PER_PHASE / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // Fetch, preceded by whatever writes its map and pattern reads need
                    pg          = PAGE_W'($urandom_range(0, 7));
                    col         = COL_W'($urandom_range(0, 127));
                    gx          = (int'(h_scroll_set) + int'(col)) % MAP_WIDTH;
                    tcol        = gx / TILE_PIX;
                    sub         = gx % TILE_PIX;
                    rows_needed = (v_scroll_set % TILE_PIX != 0) ? 2 : 1;
                    for (k = 0; k < rows_needed; k++) begin
                        row   = (int'(v_scroll_set) / TILE_PIX + int'(pg) + k) % MAP_ROWS;
                        maddr = row * MAP_COLS + tcol;
                        if (!map_written[maddr])
                            issue(OP_MAP_WR, MADDR_W'(maddr),
                                  PADDR_W'($urandom_range(0, 255)),
                                  DATA_W'($urandom_range(0, 255)),
                                  PAGE_W'($urandom_range(0, 7)),
                                  COL_W'($urandom_range(0, 127)));
                        paddr = int'(map_tiles[maddr]) * TILE_PIX + sub;
                        if (!pattern_written[paddr])
                            issue(OP_PAT_WR, MADDR_W'($urandom_range(0, 127)),
                                  PADDR_W'(paddr),
                                  DATA_W'($urandom_range(0, 255)),
                                  PAGE_W'($urandom_range(0, 7)),
                                  COL_W'($urandom_range(0, 127)));
                    end
                    issue(OP_FETCH, MADDR_W'($urandom_range(0, 127)),
                          PADDR_W'($urandom_range(0, 255)),
                          DATA_W'($urandom_range(0, 255)), pg, col);
                end else if (pick < 75) begin
                    issue(OP_MAP_WR, MADDR_W'($urandom_range(0, 127)),
                          PADDR_W'($urandom_range(0, 255)),
                          DATA_W'($urandom_range(0, 255)),
                          PAGE_W'($urandom_range(0, 7)),
                          COL_W'($urandom_range(0, 127)));
                end else if (pick < 93) begin
                    issue(OP_PAT_WR, MADDR_W'($urandom_range(0, 127)),
                          PADDR_W'($urandom_range(0, 255)),
                          DATA_W'($urandom_range(0, 255)),
                          PAGE_W'($urandom_range(0, 7)),
                          COL_W'($urandom_range(0, 127)));
                end else begin
                    issue(OP_IGNORED, MADDR_W'($urandom_range(0, 127)),
                          PADDR_W'($urandom_range(0, 255)),
                          DATA_W'($urandom_range(0, 255)),
                          PAGE_W'($urandom_range(0, 7)),
                          COL_W'($urandom_range(0, 127)));
                end
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[tile_map_scroll_renderer.f]
sv/tms_pkg.sv
sv/tms_front.sv
sv/tms_queue.sv
sv/tms_back.sv
sv/tile_map_scroll_renderer.sv
tb/sv/tile_map_scroll_renderer_checker.sv
tb/sv/tile_map_scroll_renderer_tb.sv
